### rtl/core/rpsc_pkg.sv
// rpsc_pkg: shared types and codes of the ramped pid speed controller
// beat payloads, register file, stage payload, op and register index codes
// no dependencies
package rpsc_pkg;

   // op codes of an input beat
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_COMMAND = 2'd1;
   localparam logic [1:0] OP_MEASURE = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_SCALED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_SCALED     = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] voltage;
      logic signed [31:0] ramped_target;
   } rsp_type;

   typedef struct packed {
      logic [30:0] ramp_step;
      logic [15:0] timeout_ticks;
      logic [23:0] kp_gain;
      logic [23:0] ki_scaled;
      logic [23:0] kd_scaled;
   } cfg_type;

   // handed from the ramp stage to the pid stage
   typedef struct packed {
      logic signed [32:0] err;
      logic signed [33:0] derr;
      logic signed [31:0] target;
      logic               clr_integral;
   } tick_type;

endpackage

### rtl/core/rpsc_ramp.sv
// rpsc_ramp: command timeout, target slew and error terms of one tick
// holds command, target, measurement, previous error and tick counter
// depends on rpsc_pkg
module rpsc_ramp #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_go,
   input  logic               cmd_load,
   input  logic               meas_load,
   input  logic signed [31:0] value,
   input  rpsc_pkg::cfg_type  cfg,
   output rpsc_pkg::tick_type tick_out
);

   localparam int NEAR_ZERO_INT = ((1 << FRAC_BITS) + 50) / 100;
   localparam logic signed [31:0] NEAR_ZERO = 32'(NEAR_ZERO_INT);

   logic signed [31:0] cmd_ff, cmd_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] meas_ff, meas_in;
   logic signed [32:0] prev_err_ff, prev_err_in;
   logic [15:0]        ticks_ff, ticks_in;

   logic [15:0]        ticks_tick;
   logic               timed_out;
   logic signed [31:0] cmd_eff;
   logic signed [32:0] diff;
   logic signed [33:0] diff2;
   logic signed [33:0] step;
   logic               step_up;
   logic               step_down;
   logic signed [32:0] slewed;
   logic signed [31:0] slewed_sat;
   logic signed [31:0] new_target;
   logic signed [32:0] err;
   logic signed [33:0] derr;

   always_comb begin
      ticks_tick = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
      timed_out  = (cfg.timeout_ticks != 16'd0) && (ticks_tick > cfg.timeout_ticks);
      cmd_eff    = timed_out ? 32'sd0 : cmd_ff;

      diff  = {cmd_eff[31], cmd_eff} - {target_ff[31], target_ff};
      diff2 = {diff, 1'b0};
      step  = $signed({3'b000, cfg.ramp_step});
      step_up   = diff2 > step;
      step_down = diff2 < -step;

      if (step_up) begin
         slewed = {target_ff[31], target_ff} + step[32:0];
      end else begin
         slewed = {target_ff[31], target_ff} - step[32:0];
      end
      // saturate to 32 bits
      if (slewed[32] != slewed[31]) begin
         slewed_sat = slewed[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         slewed_sat = slewed[31:0];
      end
      new_target = (step_up || step_down) ? slewed_sat : cmd_eff;

      err  = {new_target[31], new_target} - {meas_ff[31], meas_ff};
      derr = {err[32], err} - {prev_err_ff[32], prev_err_ff};

      tick_out.err          = err;
      tick_out.derr         = derr;
      tick_out.target       = new_target;
      // near-zero test uses the target before the slew
      tick_out.clr_integral = (target_ff < NEAR_ZERO) && (target_ff > -NEAR_ZERO);
   end

   always_comb begin
      cmd_in      = cmd_ff;
      target_in   = target_ff;
      meas_in     = meas_ff;
      prev_err_in = prev_err_ff;
      ticks_in    = ticks_ff;
      if (tick_go) begin
         ticks_in    = ticks_tick;
         cmd_in      = cmd_eff;
         target_in   = new_target;
         prev_err_in = err;
      end else if (cmd_load) begin
         cmd_in   = value;
         ticks_in = 16'd0;
      end else if (meas_load) begin
         meas_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= '0;
         target_ff   <= '0;
         meas_ff     <= '0;
         prev_err_ff <= '0;
         ticks_ff    <= '0;
      end else begin
         cmd_ff      <= cmd_in;
         target_ff   <= target_in;
         meas_ff     <= meas_in;
         prev_err_ff <= prev_err_in;
         ticks_ff    <= ticks_in;
      end
   end

`ifndef SYNTHESIS
   a_ticks_hold_at_max: assert property (@(posedge clock) disable iff (reset)
      tick_go && (ticks_ff == 16'hFFFF) |=> ticks_ff == 16'hFFFF)
      else $error("tick counter left saturation");
`endif

endmodule

### rtl/core/rpsc_pid.sv
// rpsc_pid: pd-plus-i voltage, sign clamp, integrator and output saturation
// holds the 48-bit error integral
// depends on rpsc_pkg
module rpsc_pid #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic               clear,
   input  rpsc_pkg::cfg_type  cfg,
   input  rpsc_pkg::tick_type tick_in,
   output rpsc_pkg::rsp_type  rsp_out
);

   localparam int PROD_W = 73;
   localparam int TERM_W = 62;
   localparam int SUM_W  = 64;
   localparam logic signed [PROD_W-1:0] TERM_MAX = PROD_W'(1) << 60;
   localparam logic signed [SUM_W-1:0]  V_MAX    = SUM_W'(32'h7FFF_FFFF);
   localparam logic signed [SUM_W-1:0]  V_MIN    = -(SUM_W'(1) << 31);

   // floor((gain * x) >> FRAC_BITS), magnitude limited to 2^60
   function automatic logic signed [TERM_W-1:0] scale_term(
      input logic [23:0]        gain,
      input logic signed [47:0] x
   );
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] shifted;
      prod    = $signed({1'b0, gain}) * x;
      shifted = prod >>> FRAC_BITS;
      if (shifted > TERM_MAX) begin
         shifted = TERM_MAX;
      end else if (shifted < -TERM_MAX) begin
         shifted = -TERM_MAX;
      end
      return shifted[TERM_W-1:0];
   endfunction

   logic signed [47:0] integ_ff, integ_in;

   logic signed [47:0]     integ_eff;
   logic signed [TERM_W-1:0] kp_term;
   logic signed [TERM_W-1:0] ki_term;
   logic signed [TERM_W-1:0] kd_term;
   logic signed [SUM_W-1:0]  v_sum;
   logic signed [SUM_W-1:0]  v_out;
   logic                   target_pos;
   logic                   target_neg;
   logic                   clamped;
   logic signed [48:0]     integ_sum;
   logic signed [47:0]     integ_sat;

   always_comb begin
      integ_eff = tick_in.clr_integral ? 48'sd0 : integ_ff;

      kp_term = scale_term(cfg.kp_gain, {{15{tick_in.err[32]}}, tick_in.err});
      ki_term = scale_term(cfg.ki_scaled, integ_eff);
      kd_term = scale_term(cfg.kd_scaled, {{14{tick_in.derr[33]}}, tick_in.derr});

      v_sum = {{2{kp_term[TERM_W-1]}}, kp_term}
            + {{2{ki_term[TERM_W-1]}}, ki_term}
            + {{2{kd_term[TERM_W-1]}}, kd_term};

      target_pos = !tick_in.target[31] && (tick_in.target != 32'sd0);
      target_neg = tick_in.target[31];
      // voltage opposing the target direction is held at zero
      clamped = (target_pos && v_sum < 0) || (target_neg && v_sum > 0);
      v_out   = clamped ? '0 : v_sum;

      integ_sum = {integ_eff[47], integ_eff} + {{16{tick_in.err[32]}}, tick_in.err};
      if (integ_sum[48] != integ_sum[47]) begin
         integ_sat = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         integ_sat = integ_sum[47:0];
      end

      priority if (go) begin
         integ_in = clamped ? integ_eff : integ_sat;
      end else if (clear) begin
         integ_in = '0;
      end else begin
         integ_in = integ_ff;
      end

      priority if (v_out > V_MAX) begin
         rsp_out.voltage = 32'sh7FFF_FFFF;
      end else if (v_out < V_MIN) begin
         rsp_out.voltage = 32'sh8000_0000;
      end else begin
         rsp_out.voltage = v_out[31:0];
      end
      rsp_out.ramped_target = tick_in.target;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

`ifndef SYNTHESIS
   a_voltage_follows_target: assert property (@(posedge clock) disable iff (reset)
      go && target_pos |-> !rsp_out.voltage[31])
      else $error("negative voltage with positive target");
`endif

endmodule

### rtl/core/ramped_pid_speed_controller_core.sv
// ramped_pid_speed_controller_core: top level of the ramped pid speed controller
// input register, ramp stage, pid stage, result register and register file
// depends on rpsc_pkg, rpsc_ramp, rpsc_pid
//
//   channel | ports                              | direction | carries
//   req     | req_valid req_ready req_data       | in        | op, value
//   rsp     | rsp_valid rsp_ready rsp_data       | out       | voltage, ramped_target
//   csr     | csr_valid csr_ready csr_index/wdata| in        | register writes
//
// one beat per cycle sustained while rsp is not stalled; a tick passes through the
// input register, the ramp stage, then the pid multiplies into the result register
// command and measurement beats leave the input register the cycle after they arrive
// reset is synchronous and clears config, valid flags and state, not the data registers; csr_ready is always high
// a stalled rsp holds the result register and backs up stage by stage to req_ready
module ramped_pid_speed_controller_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rpsc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rpsc_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rpsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);

   rpsc_pkg::cfg_type  cfg_ff, cfg_in;
   logic               s0_v_ff, s0_v_in;
   rpsc_pkg::req_type  s0_ff;
   logic               s1_v_ff, s1_v_in;
   rpsc_pkg::tick_type s1_ff;
   logic               rsp_v_ff, rsp_v_in;
   rpsc_pkg::rsp_type  rsp_ff;

   rpsc_pkg::tick_type tick_next;
   rpsc_pkg::rsp_type  rsp_next;
   logic               out_free;
   logic               s1_go;
   logic               s1_free;
   logic               s0_is_tick;
   logic               s0_go;
   logic               req_accept;
   logic               tick_go;
   logic               cmd_load;
   logic               meas_load;
   logic               csr_hit;

   always_comb begin
      out_free   = !rsp_v_ff || rsp_ready;
      s1_go      = s1_v_ff && out_free;
      s1_free    = !s1_v_ff || s1_go;
      s0_is_tick = s0_ff.op == rpsc_pkg::OP_TICK;
      // only ticks need room downstream
      s0_go      = s0_v_ff && (!s0_is_tick || s1_free);
      req_ready  = !s0_v_ff || s0_go;
      req_accept = req_valid && req_ready;
      tick_go    = s0_go && s0_is_tick;
      cmd_load   = s0_go && (s0_ff.op == rpsc_pkg::OP_COMMAND);
      meas_load  = s0_go && (s0_ff.op == rpsc_pkg::OP_MEASURE);

      s0_v_in  = req_accept || (s0_v_ff && !s0_go);
      s1_v_in  = tick_go || (s1_v_ff && !s1_go);
      rsp_v_in = s1_go || (rsp_v_ff && !rsp_ready);
   end

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in  = cfg_ff;
      csr_hit = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            rpsc_pkg::CSR_RAMP_STEP: begin
               cfg_in.ramp_step = csr_wdata[30:0];
               csr_hit          = 1'b1;
            end
            rpsc_pkg::CSR_TIMEOUT_TICKS: begin
               cfg_in.timeout_ticks = csr_wdata[15:0];
               csr_hit              = 1'b1;
            end
            rpsc_pkg::CSR_KP_GAIN: begin
               cfg_in.kp_gain = csr_wdata[23:0];
               csr_hit        = 1'b1;
            end
            rpsc_pkg::CSR_KI_SCALED: begin
               cfg_in.ki_scaled = csr_wdata[23:0];
               csr_hit          = 1'b1;
            end
            rpsc_pkg::CSR_KD_SCALED: begin
               cfg_in.kd_scaled = csr_wdata[23:0];
               csr_hit          = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   rpsc_ramp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ramp (
      .clock     (clock),
      .reset     (reset),
      .tick_go   (tick_go),
      .cmd_load  (cmd_load),
      .meas_load (meas_load),
      .value     (s0_ff.value),
      .cfg       (cfg_ff),
      .tick_out  (tick_next)
   );

   rpsc_pid #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pid (
      .clock   (clock),
      .reset   (reset),
      .go      (s1_go),
      .clear   (csr_hit),
      .cfg     (cfg_ff),
      .tick_in (s1_ff),
      .rsp_out (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         s0_v_ff  <= s0_v_in;
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_ff <= req_data;
      end
      if (tick_go) begin
         s1_ff <= tick_next;
      end
      if (s1_go) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_go |=> s1_v_ff && $stable(s1_ff))
      else $error("pid stage overwritten while stalled");
   a_non_tick_drains: assert property (@(posedge clock) disable iff (reset)
      s0_v_ff && !s0_is_tick |-> s0_go)
      else $error("command or measurement beat stalled");
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s0_v_ff && !s1_v_ff && !rsp_v_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
